// ===== sv/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// Next-cycle implication, masked during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

// ===== sv/srcomp_pkg.sv =====
package srcomp_pkg;

   localparam int MAX_COLUMNS  = 16;
   localparam int ELEMENT_BITS = 32;

   localparam int ELEMENT_WIDTH  = 32;
   localparam int WORD_WIDTH     = 32;
   localparam int KIND_WIDTH     = 2;
   localparam int COLS_CFG_BITS  = 5;
   localparam int ROWS_CFG_BITS  = 16;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 16;

   localparam int PAIR_ADDR_BITS = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int COUNT_BITS     = $clog2(MAX_COLUMNS + 1);

   localparam logic [ELEMENT_WIDTH-1:0] ELEMENT_MASK =
      (ELEMENT_BITS >= ELEMENT_WIDTH) ? {ELEMENT_WIDTH{1'b1}} :
      ELEMENT_WIDTH'((65'd1 << ELEMENT_BITS) - 65'd1);

   // Result word kinds
   localparam logic [KIND_WIDTH-1:0] KIND_COUNT  = 2'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_COLUMN = 2'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_VALUE  = 2'd2;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COLUMNS = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROWS    = 1'd1;

   typedef struct packed {
      logic [PAIR_ADDR_BITS-1:0] column;
      logic [ELEMENT_WIDTH-1:0]  value;
   } pair_type;

endpackage

// ===== sv/sparse_row_compressor_unit.sv =====
// Sparse row compressor.
// req_ channel: dense matrix elements in row-major order, one per transaction.
// rsp_ channel: per row, a count word, then a column word and a value word for
//   each nonzero in ascending column order; row_done marks the last word of a
//   row, matrix_done the last word of the final row.
// csr_ channel: index 0 sets columns per row, index 1 rows per matrix; always
//   ready; the user writes it only while the block is idle; no check enforces it.
// Throughput: an element that does not end a row keeps the input ready. The
//   element that ends a row is followed by the count word and, per nonzero, a
//   column and a value word, one word per cycle unless the receiver stalls, with
//   one pair RAM read per pair, issued as the count or prior value word loads.
//   No input is taken meanwhile. The count word is loaded from the COUNT state.
// A stalled receiver holds the output register; the sequencer waits on it.
// Reset (synchronous, active high) clears the column, count and row positions,
//   sets 16 columns and 1 row, and empties the output register. The pair RAM
//   needs no clearing: only pairs written in the current row are read.
module sparse_row_compressor_unit import srcomp_pkg::*; (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic signed [ELEMENT_WIDTH-1:0] req_element,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [WORD_WIDTH-1:0]    rsp_word,
   output logic [KIND_WIDTH-1:0]           rsp_word_kind,
   output logic                            rsp_row_done,
   output logic                            rsp_matrix_done,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]       csr_index,
   input  logic [CSR_DATA_BITS-1:0]        csr_data
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_COUNT = 2'd1;
   localparam logic [1:0] ST_COL   = 2'd2;
   localparam logic [1:0] ST_VAL   = 2'd3;

   logic [1:0]                state_ff, state_in;
   logic [COLS_CFG_BITS-1:0]  cols_cfg_ff, cols_cfg_in;
   logic [ROWS_CFG_BITS-1:0]  rows_cfg_ff, rows_cfg_in;
   logic [PAIR_ADDR_BITS-1:0] colpos_ff, colpos_in;
   logic [COUNT_BITS-1:0]     count_ff, count_in;
   logic [ROWS_CFG_BITS-1:0]  rowpos_ff, rowpos_in;
   logic                      final_ff, final_in;
   logic [PAIR_ADDR_BITS-1:0] idx_ff, idx_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [WORD_WIDTH-1:0]     word_ff, word_in;
   logic [KIND_WIDTH-1:0]     kind_ff, kind_in;
   logic                      row_done_ff, row_done_in;
   logic                      mdone_ff, mdone_in;

   logic                      wr_en, rd_en;
   logic [PAIR_ADDR_BITS-1:0] rd_addr;
   pair_type                  wr_data, rd_data;

   logic [COLS_CFG_BITS-1:0]  cols_eff;
   logic [ROWS_CFG_BITS-1:0]  rows_eff;
   logic [ELEMENT_WIDTH-1:0]  value;
   logic                      can_load, req_take, last_pair;
   logic [COUNT_BITS-1:0]     count_next;

   srcomp_pair_ram u_pair_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[PAIR_ADDR_BITS-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      if (cols_cfg_ff == '0) begin
         cols_eff = COLS_CFG_BITS'(1);
      end else if (cols_cfg_ff > COLS_CFG_BITS'(MAX_COLUMNS)) begin
         cols_eff = COLS_CFG_BITS'(MAX_COLUMNS);
      end else begin
         cols_eff = cols_cfg_ff;
      end
      rows_eff = (rows_cfg_ff == '0) ? ROWS_CFG_BITS'(1) : rows_cfg_ff;
   end

   assign value          = req_element & ELEMENT_MASK;
   assign wr_data.column = colpos_ff;
   assign wr_data.value  = value;
   assign req_ready      = (state_ff == ST_IDLE);
   assign req_take       = req_valid && req_ready;
   assign can_load       = !rsp_valid_ff || rsp_ready;
   assign last_pair      = (COUNT_BITS'(idx_ff) + COUNT_BITS'(1)) == count_ff;
   assign csr_ready      = 1'b1;

   always_comb begin
      cols_cfg_in = cols_cfg_ff;
      rows_cfg_in = rows_cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_COLUMNS: cols_cfg_in = csr_data[COLS_CFG_BITS-1:0];
            CSR_ROWS:    rows_cfg_in = csr_data[ROWS_CFG_BITS-1:0];
            default:     ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      colpos_in    = colpos_ff;
      count_in     = count_ff;
      rowpos_in    = rowpos_ff;
      final_in     = final_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      word_in      = word_ff;
      kind_in      = kind_ff;
      row_done_in  = row_done_ff;
      mdone_in     = mdone_ff;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = idx_ff;
      count_next   = count_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (value != '0 && count_ff < COUNT_BITS'(MAX_COLUMNS)) begin
                  wr_en      = 1'b1;
                  count_next = count_ff + COUNT_BITS'(1);
               end
               count_in = count_next;
               if ((COLS_CFG_BITS'(colpos_ff) + COLS_CFG_BITS'(1)) < cols_eff) begin
                  colpos_in = colpos_ff + PAIR_ADDR_BITS'(1);
               end else begin
                  final_in = ({1'b0, rowpos_ff} + 17'd1) >= {1'b0, rows_eff};
                  state_in = ST_COUNT;
               end
            end
         end
         ST_COUNT: begin
            if (can_load) begin
               rsp_valid_in = 1'b1;
               word_in      = WORD_WIDTH'(count_ff);
               kind_in      = KIND_COUNT;
               row_done_in  = (count_ff == '0);
               mdone_in     = (count_ff == '0) && final_ff;
               if (count_ff == '0) begin
                  colpos_in = '0;
                  rowpos_in = final_ff ? '0 : rowpos_ff + ROWS_CFG_BITS'(1);
                  state_in  = ST_IDLE;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = '0;
                  idx_in   = '0;
                  state_in = ST_COL;
               end
            end
         end
         ST_COL: begin
            if (can_load) begin
               rsp_valid_in = 1'b1;
               word_in      = WORD_WIDTH'(rd_data.column);
               kind_in      = KIND_COLUMN;
               row_done_in  = 1'b0;
               mdone_in     = 1'b0;
               state_in     = ST_VAL;
            end
         end
         ST_VAL: begin
            if (can_load) begin
               rsp_valid_in = 1'b1;
               word_in      = rd_data.value;
               kind_in      = KIND_VALUE;
               row_done_in  = last_pair;
               mdone_in     = last_pair && final_ff;
               if (last_pair) begin
                  colpos_in = '0;
                  count_in  = '0;
                  rowpos_in = final_ff ? '0 : rowpos_ff + ROWS_CFG_BITS'(1);
                  state_in  = ST_IDLE;
               end else begin
                  // advance to the next pair and fetch it while the value word loads
                  idx_in   = idx_ff + PAIR_ADDR_BITS'(1);
                  rd_en    = 1'b1;
                  rd_addr  = idx_ff + PAIR_ADDR_BITS'(1);
                  state_in = ST_COL;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cols_cfg_ff  <= COLS_CFG_BITS'(16);
         rows_cfg_ff  <= ROWS_CFG_BITS'(1);
         colpos_ff    <= '0;
         count_ff     <= '0;
         rowpos_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cols_cfg_ff  <= cols_cfg_in;
         rows_cfg_ff  <= rows_cfg_in;
         colpos_ff    <= colpos_in;
         count_ff     <= count_in;
         rowpos_ff    <= rowpos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      final_ff    <= final_in;
      idx_ff      <= idx_in;
      word_ff     <= word_in;
      kind_ff     <= kind_in;
      row_done_ff <= row_done_in;
      mdone_ff    <= mdone_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_word        = word_ff;
   assign rsp_word_kind   = kind_ff;
   assign rsp_row_done    = row_done_ff;
   assign rsp_matrix_done = mdone_ff;

endmodule

// ===== sv/srcomp_pair_ram.sv =====
module srcomp_pair_ram import srcomp_pkg::*; (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [PAIR_ADDR_BITS-1:0] wr_addr,
   input  pair_type                  wr_data,
   input  logic                      rd_en,
   input  logic [PAIR_ADDR_BITS-1:0] rd_addr,
   output pair_type                  rd_data
);

   pair_type mem [MAX_COLUMNS];
   pair_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Hold the read data until the next read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/srcomp_checker.sv =====
`include "assert_macros.svh"

module srcomp_checker import srcomp_pkg::*; (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic signed [WORD_WIDTH-1:0]    rsp_word,
   input logic [KIND_WIDTH-1:0]           rsp_word_kind,
   input logic                            rsp_row_done,
   input logic                            rsp_matrix_done
);

   // Hold a stalled result.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word) && $stable(rsp_word_kind))

   `ASSERT_IMPLIES(a_matrix_in_row, clock, reset, rsp_valid && rsp_matrix_done, rsp_row_done)

   // A count word closes its row exactly when the row was empty, and never exceeds MAX_COLUMNS.
   `ASSERT_IMPLIES(a_empty_row, clock, reset, rsp_valid && rsp_word_kind == KIND_COUNT, rsp_row_done == (rsp_word == '0) && rsp_word <= WORD_WIDTH'(MAX_COLUMNS))

   `ASSERT_IMPLIES(a_column_range, clock, reset, rsp_valid && rsp_word_kind == KIND_COLUMN, rsp_word < WORD_WIDTH'(MAX_COLUMNS) && !rsp_row_done)

   // Accept no input while a column word of a row is on the output.
   `ASSERT_IMPLIES(a_no_input_mid_row, clock, reset, rsp_valid && rsp_word_kind == KIND_COLUMN, !req_ready)

endmodule

bind sparse_row_compressor_unit srcomp_checker u_srcomp_checker (.*);
